// ----- rtl/wpb_pkg.sv -----
// ---------------------------------------------------------------------------
// W' balance tracker package
// Shared widths, fixed-point constants and the reciprocal table used by the
// series stage of the exponential.
// ---------------------------------------------------------------------------
package wpb_pkg;

   localparam int TIME_W  = 32;
   localparam int POWER_W = 12;
   localparam int WORK_W  = 40;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int DIV_N_W = 61;
   localparam int DIV_D_W = 26;
   localparam int CNT_W   = 6;

   localparam logic [POWER_W-1:0] CP_RESET      = 12'd250;
   localparam logic [WORK_W-1:0]  WORK_MAX      = 40'hFF_FFFF_FFFF;
   localparam logic [MUL_W-1:0]   Q32_ONE       = 33'h1_0000_0000;
   localparam logic [MUL_W-1:0]   EXP_NEG_ONE   = 33'd1580030169;
   localparam logic [DIV_D_W-1:0] TAU_OFFSET    = 26'd20709376;
   localparam logic [MUL_W-1:0]   TAU_SCALE     = 33'd546;
   // ceil(2^35 / 100): product >> 35 gives the exact quotient below 2^30
   localparam logic [MUL_W-1:0]   RECIP_100     = 33'd343597384;
   localparam logic [4:0]         SERIES_LAST   = 5'd16;
   localparam logic [4:0]         INT_PART_MAX  = 5'd23;

   // floor(2^32 / k) for the series divide-by-k steps
   function automatic logic [MUL_W-1:0] recip(input logic [4:0] k);
      logic [MUL_W-1:0] r;
      case (k)
         5'd1:    r = 33'd4294967296;
         5'd2:    r = 33'd2147483648;
         5'd3:    r = 33'd1431655765;
         5'd4:    r = 33'd1073741824;
         5'd5:    r = 33'd858993459;
         5'd6:    r = 33'd715827882;
         5'd7:    r = 33'd613566756;
         5'd8:    r = 33'd536870912;
         5'd9:    r = 33'd477218588;
         5'd10:   r = 33'd429496729;
         5'd11:   r = 33'd390451572;
         5'd12:   r = 33'd357913941;
         5'd13:   r = 33'd330382099;
         5'd14:   r = 33'd306783378;
         5'd15:   r = 33'd286331153;
         5'd16:   r = 33'd268435456;
         default: r = 33'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/wpb_mul.sv -----
// ---------------------------------------------------------------------------
// W' balance shared multiplier
// Unsigned 33 x 33 multiply with a registered product.
// ---------------------------------------------------------------------------
module wpb_mul (
   input  logic                        clock,
   input  logic [wpb_pkg::MUL_W-1:0]   op_a,
   input  logic [wpb_pkg::MUL_W-1:0]   op_b,
   output logic [wpb_pkg::PROD_W-1:0]  prod
);

   logic [wpb_pkg::PROD_W-1:0] prod_ff;
   logic [wpb_pkg::PROD_W-1:0] prod_in;

   assign prod_in = wpb_pkg::PROD_W'(op_a) * wpb_pkg::PROD_W'(op_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- rtl/wpb_div.sv -----
// ---------------------------------------------------------------------------
// W' balance shared divider
// Restoring divider, one quotient bit per cycle, 61-bit dividend.
// ---------------------------------------------------------------------------
module wpb_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [wpb_pkg::DIV_N_W-1:0]  num,
   input  logic [wpb_pkg::DIV_D_W-1:0]  den,
   output logic                         done,
   output logic [wpb_pkg::DIV_N_W-1:0]  quo
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [wpb_pkg::CNT_W-1:0]   cnt_ff;
   logic [wpb_pkg::DIV_N_W-1:0] nq_ff;
   logic [wpb_pkg::DIV_D_W-1:0] rem_ff;
   logic [wpb_pkg::DIV_D_W-1:0] den_ff;
   logic [wpb_pkg::DIV_D_W:0]   rem_sh;
   logic [wpb_pkg::DIV_D_W:0]   rem_sub;
   logic                        q_bit;

   assign rem_sh  = {rem_ff, nq_ff[wpb_pkg::DIV_N_W-1]};
   assign q_bit   = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign done    = done_ff;
   assign quo     = nq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            nq_ff   <= num;
            den_ff  <= den;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= q_bit ? rem_sub[wpb_pkg::DIV_D_W-1:0] : rem_sh[wpb_pkg::DIV_D_W-1:0];
            nq_ff  <= {nq_ff[wpb_pkg::DIV_N_W-2:0], q_bit};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == wpb_pkg::CNT_W'(wpb_pkg::DIV_N_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ----- rtl/w_prime_balance_tracker.sv -----
// ---------------------------------------------------------------------------
// W' balance tracker
// W' expended per ride sample, exponential recovery below critical power.
//
//   channel  dir  payload                                   handshake
//   req      in   time_stamp[31:0], power[43:32]            tvalid/tready
//   rsp      out  w_expended[39:0]                          tvalid/tready
//   csr      in   critical_power[11:0]                      wr_en only
//
// A sample at or below critical power takes a reciprocal multiply for the tau
// exponent, one pass of the bit-serial divider and two exponentials on the
// shared multiplier (16 series terms, then up to 23 scaling steps; an exponent
// past 23 skips both). A sample above critical power needs only the work
// multiply and accumulate; the very first sample returns zero directly.
// Reset is synchronous; critical power resets to 250 W.
// A stalled result holds in the output register; the next sample is taken.
// ---------------------------------------------------------------------------
module w_prime_balance_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // time_stamp[31:0], power[43:32], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // w_expended[39:0]
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_WORK_MUL, ST_WORK_ACC, ST_TAU_DIV, ST_TAU_QUO, ST_EXP_INIT,
      ST_EXP_MT, ST_EXP_MD, ST_EXP_MQ, ST_EXP_FIN, ST_EXP_PM, ST_EXP_PA,
      ST_TAU_MUL, ST_TAU_ACC, ST_REC_DIV, ST_REC_FIN, ST_OUT_LO, ST_OUT_HI,
      ST_OUT_SUM, ST_DONE
   } state_type;

   state_type                       state_ff;
   logic [wpb_pkg::POWER_W-1:0]     critical_power_ff;
   logic [wpb_pkg::TIME_W-1:0]      prev_time_ff;
   logic                            have_prev_ff;
   logic                            prev_supra_ff;
   logic [wpb_pkg::WORK_W-1:0]      run_work_ff;
   logic [wpb_pkg::TIME_W-1:0]      run_rec_ff;
   logic [wpb_pkg::WORK_W-1:0]      base_ff;
   logic [wpb_pkg::WORK_W-1:0]      last_out_ff;
   logic [wpb_pkg::TIME_W-1:0]      dt_ff;
   logic [wpb_pkg::POWER_W-1:0]     excess_ff;
   logic [wpb_pkg::POWER_W-1:0]     deficit_ff;
   logic [wpb_pkg::DIV_N_W-1:0]     exp_x_ff;
   logic                            exp_sel_ff;
   logic [wpb_pkg::MUL_W-1:0]       term_ff;
   logic [wpb_pkg::MUL_W:0]         pos_ff;
   logic [wpb_pkg::MUL_W:0]         neg_ff;
   logic [4:0]                      k_ff;
   logic [wpb_pkg::TIME_W-1:0]      v_ff;
   logic [wpb_pkg::MUL_W-1:0]       exp_r_ff;
   logic [4:0]                      pw_cnt_ff;
   logic [24:0]                     rec_ff;
   logic [wpb_pkg::PROD_W-1:0]      acc_ff;
   logic [wpb_pkg::WORK_W-1:0]      res_ff;
   logic                            rsp_valid_ff;
   logic [wpb_pkg::WORK_W-1:0]      rsp_data_ff;

   logic [wpb_pkg::TIME_W-1:0]      t_in;
   logic [wpb_pkg::POWER_W-1:0]     p_in;
   logic                            accept;
   logic                            supra;
   logic                            change;
   logic [wpb_pkg::TIME_W-1:0]      dt;
   logic [wpb_pkg::TIME_W-1:0]      rec_base;
   logic [wpb_pkg::TIME_W:0]        rec_sum;
   logic [wpb_pkg::POWER_W-1:0]     deficit;

   logic [wpb_pkg::MUL_W-1:0]       mul_a;
   logic [wpb_pkg::MUL_W-1:0]       mul_b;
   logic [wpb_pkg::PROD_W-1:0]      mul_p;
   logic                            div_start;
   logic [wpb_pkg::DIV_N_W-1:0]     div_num;
   logic [wpb_pkg::DIV_D_W-1:0]     div_den;
   logic                            div_done;
   logic [wpb_pkg::DIV_N_W-1:0]     div_quo;

   logic [wpb_pkg::TIME_W-1:0]      q_est;
   logic [36:0]                     qk;
   logic [wpb_pkg::TIME_W-1:0]      q_rem;
   logic [wpb_pkg::MUL_W-1:0]       term_new;
   logic [wpb_pkg::WORK_W-1:0]      room;
   logic [wpb_pkg::WORK_W-1:0]      rw_new;
   logic [wpb_pkg::WORK_W:0]        sum41;
   logic [41:0]                     tau_rnd;
   logic [wpb_pkg::DIV_D_W-1:0]     tau;
   logic [wpb_pkg::MUL_W:0]         pw_rnd;
   logic [wpb_pkg::MUL_W:0]         rec_rnd;
   logic [wpb_pkg::PROD_W-1:0]      out_sum;

   assign t_in    = req_tdata[31:0];
   assign p_in    = req_tdata[43:32];
   assign req_tready = state_ff == ST_IDLE;
   assign accept  = req_tvalid && req_tready;
   assign supra   = p_in > critical_power_ff;
   assign change  = supra != prev_supra_ff;
   assign dt      = t_in - prev_time_ff;
   assign deficit = critical_power_ff - p_in;
   assign rec_base = change ? '0 : run_rec_ff;
   assign rec_sum  = {1'b0, rec_base} + {1'b0, dt};

   assign q_est    = mul_p[63:32];
   assign qk       = 37'(q_est) * 37'(k_ff);
   assign q_rem    = v_ff - qk[31:0];
   assign term_new = (q_rem >= 32'(k_ff)) ? {1'b0, q_est} + 1'b1 : {1'b0, q_est};

   assign room   = wpb_pkg::WORK_MAX - run_work_ff;
   assign rw_new = ({4'd0, room} <= mul_p[43:0]) ? wpb_pkg::WORK_MAX
                                                 : run_work_ff + mul_p[39:0];
   assign sum41  = {1'b0, base_ff} + {1'b0, rw_new};

   assign tau_rnd = mul_p[41:0] + 42'd32768;
   assign tau     = tau_rnd[41:16] + wpb_pkg::TAU_OFFSET;
   assign pw_rnd  = {1'b0, mul_p[64:32]} + {33'd0, mul_p[31]};
   assign rec_rnd = {1'b0, exp_r_ff} + 34'd128;
   assign out_sum = acc_ff + {mul_p[33:0], 32'd0} + 66'h80_0000;

   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (state_ff)
         ST_WORK_MUL: begin
            mul_a = {1'b0, dt_ff};
            mul_b = wpb_pkg::MUL_W'(excess_ff);
         end
         ST_TAU_DIV: begin
            mul_a = wpb_pkg::MUL_W'({deficit_ff, 16'd0}) + 33'd50;
            mul_b = wpb_pkg::RECIP_100;
         end
         ST_EXP_MT: begin
            mul_a = term_ff;
            mul_b = {1'b0, exp_x_ff[15:0], 16'd0};
         end
         ST_EXP_MD: begin
            mul_a = {1'b0, mul_p[63:32]};
            mul_b = wpb_pkg::recip(k_ff);
         end
         ST_EXP_PM: begin
            mul_a = exp_r_ff;
            mul_b = wpb_pkg::EXP_NEG_ONE;
         end
         ST_TAU_MUL: begin
            mul_a = exp_r_ff;
            mul_b = wpb_pkg::TAU_SCALE;
         end
         ST_TAU_ACC: begin
            div_start = 1'b1;
            div_num   = {1'b0, run_rec_ff, 28'd0} + wpb_pkg::DIV_N_W'(tau[25:1]);
            div_den   = tau;
         end
         ST_OUT_LO: begin
            mul_a = {1'b0, base_ff[31:0]};
            mul_b = wpb_pkg::MUL_W'(rec_ff);
         end
         ST_OUT_HI: begin
            mul_a = wpb_pkg::MUL_W'(base_ff[39:32]);
            mul_b = wpb_pkg::MUL_W'(rec_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   wpb_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   wpb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         critical_power_ff <= wpb_pkg::CP_RESET;
         prev_time_ff      <= '0;
         have_prev_ff      <= 1'b0;
         prev_supra_ff     <= 1'b0;
         run_work_ff       <= '0;
         run_rec_ff        <= '0;
         base_ff           <= '0;
         last_out_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
         rsp_data_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            critical_power_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  prev_time_ff <= t_in;
                  dt_ff        <= dt;
                  excess_ff    <= p_in - critical_power_ff;
                  deficit_ff   <= deficit;
                  if (!have_prev_ff) begin
                     have_prev_ff  <= 1'b1;
                     prev_supra_ff <= supra;
                     run_work_ff   <= '0;
                     run_rec_ff    <= '0;
                     base_ff       <= '0;
                     res_ff        <= '0;
                     state_ff      <= ST_DONE;
                  end else begin
                     if (change) begin
                        base_ff       <= last_out_ff;
                        run_work_ff   <= '0;
                        prev_supra_ff <= supra;
                     end
                     if (supra) begin
                        run_rec_ff <= rec_base;
                        state_ff   <= ST_WORK_MUL;
                     end else begin
                        run_rec_ff <= rec_sum[32] ? '1 : rec_sum[31:0];
                        state_ff   <= ST_TAU_DIV;
                     end
                  end
               end
            end
            ST_WORK_MUL: begin
               state_ff <= ST_WORK_ACC;
            end
            ST_WORK_ACC: begin
               run_work_ff <= rw_new;
               res_ff      <= sum41[40] ? wpb_pkg::WORK_MAX : sum41[39:0];
               state_ff    <= ST_DONE;
            end
            ST_TAU_DIV: begin
               state_ff <= ST_TAU_QUO;
            end
            ST_TAU_QUO: begin
               exp_x_ff   <= wpb_pkg::DIV_N_W'(mul_p[65:35]);
               exp_sel_ff <= 1'b0;
               state_ff   <= ST_EXP_INIT;
            end
            ST_EXP_INIT: begin
               term_ff <= wpb_pkg::Q32_ONE;
               pos_ff  <= {1'b0, wpb_pkg::Q32_ONE};
               neg_ff  <= '0;
               k_ff    <= 5'd1;
               if (exp_x_ff[60:16] > 45'(wpb_pkg::INT_PART_MAX)) begin
                  exp_r_ff <= '0;
                  state_ff <= exp_sel_ff ? ST_REC_FIN : ST_TAU_MUL;
               end else begin
                  state_ff <= ST_EXP_MT;
               end
            end
            ST_EXP_MT: begin
               state_ff <= ST_EXP_MD;
            end
            ST_EXP_MD: begin
               v_ff     <= mul_p[63:32];
               state_ff <= ST_EXP_MQ;
            end
            ST_EXP_MQ: begin
               term_ff <= term_new;
               if (k_ff[0]) begin
                  neg_ff <= neg_ff + {1'b0, term_new};
               end else begin
                  pos_ff <= pos_ff + {1'b0, term_new};
               end
               k_ff     <= k_ff + 1'b1;
               state_ff <= (k_ff == wpb_pkg::SERIES_LAST) ? ST_EXP_FIN : ST_EXP_MT;
            end
            ST_EXP_FIN: begin
               exp_r_ff  <= (pos_ff >= neg_ff) ? 33'(pos_ff - neg_ff) : '0;
               pw_cnt_ff <= exp_x_ff[20:16];
               if (exp_x_ff[20:16] == 5'd0) begin
                  state_ff <= exp_sel_ff ? ST_REC_FIN : ST_TAU_MUL;
               end else begin
                  state_ff <= ST_EXP_PM;
               end
            end
            ST_EXP_PM: begin
               state_ff <= ST_EXP_PA;
            end
            ST_EXP_PA: begin
               exp_r_ff  <= pw_rnd[32:0];
               pw_cnt_ff <= pw_cnt_ff - 1'b1;
               if (pw_cnt_ff == 5'd1) begin
                  state_ff <= exp_sel_ff ? ST_REC_FIN : ST_TAU_MUL;
               end else begin
                  state_ff <= ST_EXP_PM;
               end
            end
            ST_TAU_MUL: begin
               state_ff <= ST_TAU_ACC;
            end
            ST_TAU_ACC: begin
               state_ff <= ST_REC_DIV;
            end
            ST_REC_DIV: begin
               if (div_done) begin
                  exp_x_ff   <= div_quo;
                  exp_sel_ff <= 1'b1;
                  state_ff   <= ST_EXP_INIT;
               end
            end
            ST_REC_FIN: begin
               rec_ff   <= rec_rnd[32:8];
               state_ff <= ST_OUT_LO;
            end
            ST_OUT_LO: begin
               state_ff <= ST_OUT_HI;
            end
            ST_OUT_HI: begin
               acc_ff   <= mul_p;
               state_ff <= ST_OUT_SUM;
            end
            ST_OUT_SUM: begin
               res_ff   <= out_sum[63:24];
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  last_out_ff  <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_TAU_DIV || state_ff == ST_REC_DIV))
      else $error("divider finished outside a divide wait");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("input ready straight after a transfer");

   a_out_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata == last_out_ff)
      else $error("pending result differs from held output");

   a_series_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXP_MQ |-> (k_ff != 5'd0 && k_ff <= wpb_pkg::SERIES_LAST))
      else $error("series index out of range");

endmodule

// ----- verif/w_prime_balance_tracker_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// W' balance tracker testbench
// Streams ride samples into the tracker under random sender and receiver
// idling and checks every W' expended value against a fixed-point predictor
// of the exponential-recovery model. Critical power is changed between
// phases, only while the tracker is idle.
// ---------------------------------------------------------------------------
module w_prime_balance_tracker_tb;

   localparam int IDLE_GAP   = 400;
   localparam int WATCHDOG   = 20000;
   localparam logic [63:0] E1_Q32 = 64'd1580030169;

   typedef struct packed {
      logic [wpb_pkg::TIME_W-1:0]  stamp;
      logic [wpb_pkg::POWER_W-1:0] watts;
   } sample_type;

   typedef struct {
      logic [wpb_pkg::TIME_W-1:0]  stamp;
      logic [wpb_pkg::POWER_W-1:0] watts;
      bit                          typed;
      logic [wpb_pkg::WORK_W-1:0]  w_exp;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_wr_en;
   logic [11:0] csr_wr_data;

   w_prime_balance_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // predictor state
   logic [11:0] cp_q;
   logic [31:0] prev_stamp;
   bit          have_prev;
   bit          prev_above;
   logic [63:0] run_work;
   logic [63:0] run_rest;
   logic [63:0] base_w;
   logic [63:0] last_w;

   logic [wpb_pkg::WORK_W-1:0] expected_w[$];
   int  fail_count;
   int  checked;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] exp_frac_q32(input logic [63:0] f);
      logic [63:0] term, pos, neg;
      term = 64'h1_0000_0000;
      pos  = 64'h1_0000_0000;
      neg  = 0;
      for (int k = 1; k <= 16; k++) begin
         term = ((term * f) >> 32) / k;
         if (k % 2 == 1) neg += term;
         else pos += term;
      end
      return (pos >= neg) ? pos - neg : 64'd0;
   endfunction

   function automatic logic [63:0] exp_neg_q16(input logic [63:0] x);
      logic [63:0] n, r;
      n = x >> 16;
      if (n > 23) return 64'd0;
      r = exp_frac_q32((x & 64'hFFFF) << 16);
      for (int i = 0; i < n; i++) r = (r * E1_Q32 + 64'h8000_0000) >> 32;
      return r;
   endfunction

   function automatic logic [63:0] recovered_w(input logic [11:0] cp, input logic [11:0] p);
      logic [63:0] d, a, tau, x, rec;
      logic [127:0] prod;
      d    = 64'(cp) - 64'(p);
      a    = (d * 65536 + 50) / 100;
      tau  = ((546 * exp_neg_q16(a) + 64'h8000) >> 16) + (64'd316 << 16);
      x    = ((run_rest << 28) + (tau >> 1)) / tau;
      rec  = (exp_neg_q16(x) + 128) >> 8;
      prod = 128'(base_w) * 128'(rec) + 128'h80_0000;
      return 64'(prod >> 24);
   endfunction

   task automatic reset_tracker_state();
      have_prev = 0; prev_above = 0; prev_stamp = 0;
      run_work = 0; run_rest = 0; base_w = 0; last_w = 0;
   endtask

   function automatic logic [wpb_pkg::WORK_W-1:0] predict_w_expended(input sample_type s);
      logic [63:0] dt, inc, res;
      bit above;
      above = s.watts > cp_q;
      if (!have_prev) begin
         have_prev = 1; prev_stamp = s.stamp; prev_above = above;
         run_work = 0; run_rest = 0; base_w = 0; last_w = 0;
         return '0;
      end
      dt = {32'd0, s.stamp - prev_stamp};
      prev_stamp = s.stamp;
      if (above != prev_above) begin
         base_w = last_w; run_work = 0; run_rest = 0; prev_above = above;
      end
      if (above) begin
         inc = dt * 64'(s.watts - cp_q);
         run_work = (inc >= 64'(wpb_pkg::WORK_MAX) - run_work) ? 64'(wpb_pkg::WORK_MAX)
                                                              : run_work + inc;
         res = base_w + run_work;
         if (res > 64'(wpb_pkg::WORK_MAX)) res = 64'(wpb_pkg::WORK_MAX);
      end else begin
         run_rest += dt;
         if (run_rest > 64'hFFFF_FFFF) run_rest = 64'hFFFF_FFFF;
         res = recovered_w(cp_q, s.watts);
      end
      last_w = res & 64'(wpb_pkg::WORK_MAX);
      return last_w[wpb_pkg::WORK_W-1:0];
   endfunction

   // receiver side: stall, compare, watchdog
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_w.size() == 0) begin
               $display("%0t: unexpected w_expended transfer, actual %0d", $time, rsp_tdata);
               fail_count++;
            end else begin
               if (rsp_tdata !== expected_w[0]) begin
                  $display("%0t: w_expended mismatch, expected %0d, actual %0d",
                           $time, expected_w[0], rsp_tdata);
                  fail_count++;
               end
               void'(expected_w.pop_front());
               checked++;
            end
         end
      end
   end

   task automatic send_sample(input sample_type s, input bit typed,
                              input logic [wpb_pkg::WORK_W-1:0] w);
      logic [wpb_pkg::WORK_W-1:0] p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, s.watts, s.stamp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = predict_w_expended(s);
      if (typed && p !== w) begin
         $display("%0t: directed row disagrees, expected %0d, predicted %0d", $time, w, p);
         fail_count++;
      end
      expected_w.push_back(typed ? w : p);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_w.size() != 0) @(negedge clock);
      repeat (IDLE_GAP) @(negedge clock);
   endtask

   task automatic write_cp(input logic [11:0] v);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cp_q = v;
   endtask

   task automatic random_phase(input int n);
      sample_type s;
      logic [31:0] t;
      t = $urandom;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0:       t = $urandom;
            1:       t = t + $urandom_range(65535);
            default: t = t + $urandom_range(40);
         endcase
         s.stamp = t;
         case ($urandom_range(5))
            0:       s.watts = 12'($urandom_range(4095));
            1:       s.watts = cp_q;
            default: s.watts = (cp_q > 60 && $urandom_range(1))
                               ? 12'(cp_q - $urandom_range(60))
                               : ((cp_q < 4000) ? 12'(cp_q + $urandom_range(95)) : cp_q);
         endcase
         send_sample(s, 0, '0);
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (quiet_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      row_type rows[$];
      sample_type s;
      rows = '{
         '{32'd100,        12'd0,    1, 40'd0},
         '{32'd116,        12'd4095, 1, 40'd3845 * 16},
         '{32'd116,        12'd4095, 1, 40'd3845 * 16},
         '{32'd132,        12'd250,  0, 40'd0},
         '{32'd164,        12'd0,    0, 40'd0},
         '{32'hFFFF_FFF0,  12'd0,    0, 40'd0},
         '{32'h0000_0010,  12'd251,  0, 40'd0},
         '{32'hFFFF_FFFF,  12'd4095, 1, wpb_pkg::WORK_MAX},
         '{32'h7FFF_FFFF,  12'd4095, 1, wpb_pkg::WORK_MAX},
         '{32'h8000_0000,  12'd100,  0, 40'd0},
         '{32'hFFFF_FFFF,  12'd250,  0, 40'd0},
         '{32'h0000_0100,  12'd2730, 0, 40'd0},
         '{32'h0000_0200,  12'd1365, 0, 40'd0}
      };
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0;
      csr_wr_en = 1'b0; csr_wr_data = '0; fail_count = 0; checked = 0;
      send_idle_pct = 22; recv_idle_pct = 77;
      cp_q = wpb_pkg::CP_RESET;
      reset_tracker_state();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) begin
         s.stamp = rows[i].stamp;
         s.watts = rows[i].watts;
         send_sample(s, rows[i].typed, rows[i].w_exp);
      end

      // hold off until the tracker has caught up
      drain_results();
      random_phase(300);
      write_cp(12'd0);
      random_phase(250);
      write_cp(12'd4095);
      random_phase(150);
      send_idle_pct = 77; recv_idle_pct = 22;
      write_cp(12'd180);
      random_phase(400);
      write_cp(12'($urandom_range(4095)));
      random_phase(250);
      send_idle_pct = 0; recv_idle_pct = 0;
      write_cp(12'd300);
      random_phase(600);

      drain_results();
      $display("Ran %0d directed and 1950 random samples over six critical power settings;", rows.size());
      $display("%0d results compared, %0d mismatches.", checked, fail_count);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
